[hw/rtl/blr_pkg.sv]
// shared types, constants and the control store for the line rasterizer
`default_nettype none

package blr_pkg;

    // step counter width and the step numbers of the control program
    localparam int STEP_BITS = 1;

    typedef logic [STEP_BITS-1:0] step_t;

    localparam step_t STEP_WAIT = 1'b0;
    localparam step_t STEP_WALK = 1'b1;

    // jump conditions
    typedef enum logic [1:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_LINE,
        COND_LINE_DONE
    } cond_t;

    // one control word per step
    typedef struct packed {
        logic  take_line;
        logic  emit;
        logic  advance;
        cond_t cond;
        step_t jump_step;
        step_t next_step;
    } ctrl_word_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic line_valid;
        logic line_done;
        logic stall;
    } seq_status_t;

    // control store
    function automatic ctrl_word_t ucode_rom(input step_t step);
        ctrl_word_t w;
        w = '{take_line: 1'b0, emit: 1'b0, advance: 1'b0, cond: COND_NEVER,
              jump_step: STEP_WAIT, next_step: STEP_WAIT};
        case (step)
            STEP_WAIT:
            begin
                // hold here until a line request arrives
                w.take_line = 1'b1;
                w.cond      = COND_NO_LINE;
                w.jump_step = STEP_WAIT;
                w.next_step = STEP_WALK;
            end
            STEP_WALK:
            begin
                // one pixel out and one bresenham step per cycle unless pixel_out stalls
                w.emit      = 1'b1;
                w.advance   = 1'b1;
                w.cond      = COND_LINE_DONE;
                w.jump_step = STEP_WAIT;
                w.next_step = STEP_WALK;
            end
            default:
            begin
                w.cond      = COND_ALWAYS;
                w.jump_step = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/blr_if.sv]
// valid/ready channels for line requests and pixels
`default_nettype none

interface blr_line_if #(parameter int COORD_BITS = 6);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, input ready);
    modport sink (input valid, input start_x, input start_y, input end_x,
                  input end_y, output ready);
endinterface

interface blr_pixel_if #(parameter int COORD_BITS = 6);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;

    modport source (output valid, output pixel_x, output pixel_y, output last_pixel,
                    input ready);
    modport sink (input valid, input pixel_x, input pixel_y, input last_pixel,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/bresenham_line_rasterizer_unit.sv]
// top level of the bresenham line rasterizer
`default_nettype none

// Bresenham line rasterizer for x-major lines on a 2^COORD_BITS square grid.
// A request on line_req carries two end points; the unit walks from the end
// with the smaller x to the other, one pixel per cycle on pixel_out, and sets
// last_pixel on the final one. A line of horizontal span dx gives dx+1 pixels
// and occupies the unit for the wait step that takes the request and then
// for its walk. The walk rate is set by the single decision add per step in
// the datapath; a stalled pixel_out freezes the walk. The next request is
// taken once the last pixel is in the output register, even if it has not
// yet been taken. Control runs from a two-step control store: a wait step
// that takes a request and loads the setup terms, and a walk step that emits
// a pixel and advances x, y and the decision term. Steep lines run the same
// recurrence and give a 45-degree run of dx+1 pixels.
module bresenham_line_rasterizer_unit
    import blr_pkg::*;
#(
    parameter int COORD_BITS = 6
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    blr_line_if.sink   line_req,
    blr_pixel_if.source pixel_out
);

    // decision term is signed and saturates at its largest positive value
    localparam int DEC_W = COORD_BITS + 3;
    localparam logic [DEC_W-1:0] DEC_MAX = {1'b0, {(DEC_W-1){1'b1}}};

    // sequencer interface
    ctrl_word_t  ctrl;
    seq_status_t status;

    // walk state
    logic [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0] final_x_reg, final_x_next;
    logic [DEC_W-1:0]      decision_reg, decision_next;
    logic [COORD_BITS:0]   inc_straight_reg, inc_straight_next;
    logic [COORD_BITS+1:0] inc_diagonal_reg, inc_diagonal_next;
    logic                  y_down_reg, y_down_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] pix_x_reg, pix_x_next;
    logic [COORD_BITS-1:0] pix_y_reg, pix_y_next;
    logic                  pix_last_reg, pix_last_next;

    // handshake qualifiers
    logic line_fire;
    logic slot_free;
    logic emit_fire;
    logic line_done;

    // setup terms from the request
    logic                  swap_ends;
    logic [COORD_BITS-1:0] first_x, first_y, far_x, far_y;
    logic [COORD_BITS-1:0] dx, dy;
    logic                  far_below;
    logic [DEC_W-1:0]      init_dec;

    // step terms
    logic                  dec_neg;
    logic [DEC_W:0]        dec_ext;
    logic [DEC_W:0]        dec_addend;
    logic [DEC_W:0]        dec_sum;
    logic                  dec_sat;
    logic [DEC_W-1:0]      dec_step;
    logic [COORD_BITS-1:0] y_step;

    blr_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // a request is taken only in the wait step
    assign line_req.ready = ctrl.take_line;
    assign line_fire      = line_req.valid && ctrl.take_line;

    // output slot is free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || pixel_out.ready;
    assign emit_fire = ctrl.emit && slot_free;
    assign line_done = cur_x_reg >= final_x_reg;

    assign status.line_valid = line_req.valid;
    assign status.line_done  = line_done;
    assign status.stall      = ctrl.emit && !slot_free;

    // setup: order the end points by x, take absolute deltas
    always_comb
    begin
        swap_ends = line_req.start_x > line_req.end_x;
        first_x   = swap_ends ? line_req.end_x   : line_req.start_x;
        first_y   = swap_ends ? line_req.end_y   : line_req.start_y;
        far_x     = swap_ends ? line_req.start_x : line_req.end_x;
        far_y     = swap_ends ? line_req.start_y : line_req.end_y;
        far_below = far_y < first_y;
        dx        = far_x - first_x;
        dy        = far_below ? (first_y - far_y) : (far_y - first_y);
        // 2*dy - dx
        init_dec  = {2'b00, dy, 1'b0} - {3'b000, dx};
    end

    // one bresenham step: add 2*dy on a negative term, else 2*(dy-dx) and move y
    always_comb
    begin
        dec_neg    = decision_reg[DEC_W-1];
        dec_ext    = {decision_reg[DEC_W-1], decision_reg};
        dec_addend = dec_neg ? {3'b000, inc_straight_reg}
                             : {{2{inc_diagonal_reg[COORD_BITS+1]}}, inc_diagonal_reg};
        dec_sum    = dec_ext + dec_addend;
        // positive and past the top of the term range
        dec_sat    = !dec_sum[DEC_W] && dec_sum[DEC_W-1];
        dec_step   = dec_sat ? DEC_MAX : dec_sum[DEC_W-1:0];
        if (dec_neg)
            y_step = cur_y_reg;
        else if (y_down_reg)
            y_step = cur_y_reg - 1'b1;
        else
            y_step = cur_y_reg + 1'b1;
    end

    // walk state next values
    always_comb
    begin
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        final_x_next      = final_x_reg;
        decision_next     = decision_reg;
        inc_straight_next = inc_straight_reg;
        inc_diagonal_next = inc_diagonal_reg;
        y_down_next       = y_down_reg;
        if (line_fire)
        begin
            cur_x_next        = first_x;
            cur_y_next        = first_y;
            final_x_next      = far_x;
            decision_next     = init_dec;
            inc_straight_next = {dy, 1'b0};
            inc_diagonal_next = {1'b0, dy, 1'b0} - {1'b0, dx, 1'b0};
            y_down_next       = far_below;
        end
        else if (ctrl.advance && emit_fire && !line_done)
        begin
            cur_x_next    = cur_x_reg + 1'b1;
            cur_y_next    = y_step;
            decision_next = dec_step;
        end
    end

    // output register next values
    always_comb
    begin
        out_valid_next = out_valid_reg;
        pix_x_next     = pix_x_reg;
        pix_y_next     = pix_y_reg;
        pix_last_next  = pix_last_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
            pix_x_next     = cur_x_reg;
            pix_y_next     = cur_y_reg;
            pix_last_next  = line_done;
        end
        else if (pixel_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            final_x_reg      <= '0;
            decision_reg     <= '0;
            inc_straight_reg <= '0;
            inc_diagonal_reg <= '0;
            y_down_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            cur_x_reg        <= cur_x_next;
            cur_y_reg        <= cur_y_next;
            final_x_reg      <= final_x_next;
            decision_reg     <= decision_next;
            inc_straight_reg <= inc_straight_next;
            inc_diagonal_reg <= inc_diagonal_next;
            y_down_reg       <= y_down_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // pixel payload, no reset needed
    always_ff @(posedge clk)
    begin
        pix_x_reg    <= pix_x_next;
        pix_y_reg    <= pix_y_next;
        pix_last_reg <= pix_last_next;
    end

    assign pixel_out.valid      = out_valid_reg;
    assign pixel_out.pixel_x    = pix_x_reg;
    assign pixel_out.pixel_y    = pix_y_reg;
    assign pixel_out.last_pixel = pix_last_reg;

    // the walk never passes the far end
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |-> cur_x_reg <= final_x_reg)
        else $error("walk passed the far end");

    // an emitted inner pixel moves x by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && !line_done) |=> cur_x_reg == $past(cur_x_reg) + 1'b1)
        else $error("x did not step by one");

    // the last pixel of a line sends the sequencer back to take a request
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && line_done) |=> ctrl.take_line)
        else $error("sequencer did not return to wait");

    // no request is taken while a line is being walked
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |-> !line_fire)
        else $error("request taken during walk");

endmodule

`default_nettype wire

[hw/rtl/blr_sequencer.sv]
// step counter and control store driving the rasterizer datapath
`default_nettype none

module blr_sequencer
    import blr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire seq_status_t status,
    output ctrl_word_t       ctrl
);

    step_t step_reg;
    step_t step_next;
    logic  take_jump;

    assign ctrl = ucode_rom(step_reg);

    always_comb
    begin
        case (ctrl.cond)
            COND_NEVER:     take_jump = 1'b0;
            COND_ALWAYS:    take_jump = 1'b1;
            COND_NO_LINE:   take_jump = !status.line_valid;
            COND_LINE_DONE: take_jump = status.line_done;
            default:        take_jump = 1'b1;
        endcase
    end

    always_comb
    begin
        if (status.stall)
            step_next = step_reg;
        else if (take_jump)
            step_next = ctrl.jump_step;
        else
            step_next = ctrl.next_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_WAIT;
        else
            step_reg <= step_next;
    end

    // a stalled step must not move
    assert property (@(posedge clk) disable iff (!rst_n)
        status.stall |=> step_reg == $past(step_reg))
        else $error("step moved during stall");

    // a taken jump lands on the jump step
    assert property (@(posedge clk) disable iff (!rst_n)
        (!status.stall && take_jump) |=> step_reg == $past(ctrl.jump_step))
        else $error("jump did not reach its target");

    // no jump falls through to the next step
    assert property (@(posedge clk) disable iff (!rst_n)
        (!status.stall && !take_jump) |=> step_reg == $past(ctrl.next_step))
        else $error("step did not fall through");

endmodule

`default_nettype wire
